// File: rtl/lts_pkg.sv
`timescale 1ns / 1ps

package lts_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int MAX_LEN_W = 24;
  localparam int MAX_RESULTS = 3;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_NEWLINE_MODE = 2'd0;
  localparam logic [1:0] CFG_KEEP_NEWLINE = 2'd1;
  localparam logic [1:0] CFG_MAX_LINE_LEN = 2'd2;

  // newline modes
  localparam logic [1:0] MODE_LF_ONLY = 2'd0;
  localparam logic [1:0] MODE_CRLF_LF = 2'd1;
  localparam logic [1:0] MODE_ANY     = 2'd2;

  localparam logic [MAX_LEN_W-1:0] MAX_LINE_LEN_RST = {MAX_LEN_W{1'b1}};

  typedef struct packed {
    logic [7:0] data;
    logic       bval;
    logic       lend;
    logic       lerr;
    logic       last;
  } result_t;

endpackage

// File: rtl/line_terminator_splitter.sv
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      in_valid / in_stall        in_byte, in_has_byte, in_stream_end
// out       output     out_valid / out_stall      out_byte, out_out_valid, out_line_end,
//                                                 out_length_error, out_last_result
// cfg       input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// a request is decoded in the cycle it is accepted and its 0 to 3 results land in a
// three-entry result buffer; one result leaves per cycle
// a request giving one result sustains one request per cycle while out_stall is low; one
// with more results holds in_stall while the buffer drains
// rst_n clears the line state, the sticky error and the registers, and empties the buffer
// out_stall holds the buffer head, and with it in_stall; cfg_ready is always high

module line_terminator_splitter #(
  parameter int LENGTH_BITS = lts_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          in_has_byte,
  input  logic                          in_stream_end,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_out_valid,
  output logic                          out_line_end,
  output logic                          out_length_error,
  output logic                          out_last_result,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [lts_pkg::MAX_LEN_W-1:0] cfg_data
);

  localparam int LW = (LENGTH_BITS > lts_pkg::MAX_LEN_W) ? LENGTH_BITS : lts_pkg::MAX_LEN_W;
  localparam int NACT = 6;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_CLOSE,
    ACT_OPEN,
    ACT_HOLD,
    ACT_ENDCHK
  } act_t;

  // configuration
  logic [1:0]                    mode_r;
  logic                          keep_r;
  logic [lts_pkg::MAX_LEN_W-1:0] max_len_r;

  // line state
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   cr_r, cr_nxt;
  logic                   open_r, open_nxt;
  logic                   fail_r, fail_nxt;

  // result buffer
  lts_pkg::result_t buf_r [lts_pkg::MAX_RESULTS];
  logic [1:0]       occ_r, occ_nxt;
  logic [1:0]       head_r, head_nxt;

  lts_pkg::result_t res [lts_pkg::MAX_RESULTS];
  logic [1:0]       res_cnt;

  logic [LW-1:0]          max_ext, cap_ext, lim_ext;
  logic [LENGTH_BITS-1:0] lim;
  logic                   in_acc, out_acc;

  assign cfg_ready = 1'b1;
  assign max_ext   = LW'(max_len_r);
  assign cap_ext   = LW'({LENGTH_BITS{1'b1}});
  assign lim_ext   = (max_ext < cap_ext) ? max_ext : cap_ext;
  assign lim       = lim_ext[LENGTH_BITS-1:0];

  assign out_valid        = (occ_r != 2'd0);
  assign out_byte         = buf_r[head_r].data;
  assign out_out_valid    = buf_r[head_r].bval;
  assign out_line_end     = buf_r[head_r].lend;
  assign out_length_error = buf_r[head_r].lerr;
  assign out_last_result  = buf_r[head_r].last;

  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (occ_r != 2'd0) && !((occ_r == 2'd1) && out_acc);
  assign in_acc   = in_valid && !in_stall;

  // decode the request into an action list, then run it against the line state
  always_comb begin
    act_t       kind [NACT];
    logic [7:0] abyte [NACT];
    logic [2:0] n;
    logic       skip_rest;
    logic       cr_at_end;
    logic       stop;
    logic       do_close;

    for (int i = 0; i < NACT; i++) begin
      kind[i]  = ACT_NONE;
      abyte[i] = 8'h00;
    end
    n         = 3'd0;
    skip_rest = 1'b0;

    if (!fail_r && in_has_byte) begin
      if (cr_r) begin
        if (in_byte == lts_pkg::BYTE_LF && mode_r != lts_pkg::MODE_LF_ONLY) begin
          // crlf pair ends the line, nothing else of this byte
          if (keep_r) begin
            kind[n] = ACT_EMIT; abyte[n] = lts_pkg::BYTE_CR; n = n + 3'd1;
            kind[n] = ACT_EMIT; abyte[n] = lts_pkg::BYTE_LF; n = n + 3'd1;
          end
          kind[n] = ACT_CLOSE; n = n + 3'd1;
          skip_rest = 1'b1;
        end else if (mode_r >= lts_pkg::MODE_ANY) begin
          if (keep_r) begin
            kind[n] = ACT_EMIT; abyte[n] = lts_pkg::BYTE_CR; n = n + 3'd1;
          end
          kind[n] = ACT_CLOSE; n = n + 3'd1;
        end else begin
          kind[n] = ACT_EMIT; abyte[n] = lts_pkg::BYTE_CR; n = n + 3'd1;
        end
      end
      if (!skip_rest) begin
        kind[n] = ACT_OPEN; n = n + 3'd1;
        if (in_byte == lts_pkg::BYTE_LF) begin
          if (keep_r) begin
            kind[n] = ACT_EMIT; abyte[n] = lts_pkg::BYTE_LF; n = n + 3'd1;
          end
          kind[n] = ACT_CLOSE; n = n + 3'd1;
        end else if (in_byte == lts_pkg::BYTE_CR && mode_r != lts_pkg::MODE_LF_ONLY) begin
          kind[n] = ACT_HOLD; n = n + 3'd1;
        end else begin
          kind[n] = ACT_EMIT; abyte[n] = in_byte; n = n + 3'd1;
        end
      end
    end

    cr_at_end = in_has_byte
              ? (!skip_rest && in_byte == lts_pkg::BYTE_CR && mode_r != lts_pkg::MODE_LF_ONLY)
              : cr_r;

    if (!fail_r && in_stream_end) begin
      if (cr_at_end) begin
        // held cr: terminator in mode any, else content closing the line
        if (mode_r < lts_pkg::MODE_ANY || keep_r) begin
          kind[n] = ACT_EMIT; abyte[n] = lts_pkg::BYTE_CR; n = n + 3'd1;
        end
        kind[n] = ACT_CLOSE;
      end else begin
        kind[n] = ACT_ENDCHK;
      end
    end

    len_nxt  = len_r;
    cr_nxt   = in_has_byte ? 1'b0 : cr_r;
    open_nxt = open_r;
    fail_nxt = fail_r;
    res_cnt  = 2'd0;
    stop     = 1'b0;
    for (int j = 0; j < lts_pkg::MAX_RESULTS; j++) begin
      res[j] = '0;
    end

    for (int i = 0; i < NACT; i++) begin
      do_close = 1'b0;
      if (!stop) begin
        case (kind[i])
          ACT_EMIT: begin
            if (len_nxt >= lim) begin
              if (res_cnt != 2'd3) begin
                res[res_cnt] = '{data: 8'h00, bval: 1'b0, lend: 1'b1, lerr: 1'b1, last: 1'b0};
                res_cnt = res_cnt + 2'd1;
              end
              fail_nxt = 1'b1;
              len_nxt  = '0;
              open_nxt = 1'b0;
              cr_nxt   = 1'b0;
              stop     = 1'b1;
            end else begin
              if (res_cnt != 2'd3) begin
                res[res_cnt] = '{data: abyte[i], bval: 1'b1, lend: 1'b0, lerr: 1'b0,
                                 last: 1'b0};
                res_cnt = res_cnt + 2'd1;
              end
              len_nxt = len_nxt + LENGTH_BITS'(1);
            end
          end
          ACT_CLOSE:  do_close = 1'b1;
          ACT_OPEN:   open_nxt = 1'b1;
          ACT_HOLD:   cr_nxt = 1'b1;
          ACT_ENDCHK: begin
            do_close = open_nxt;
            len_nxt  = '0;
            open_nxt = 1'b0;
            cr_nxt   = 1'b0;
          end
          default: ;
        endcase
        if (do_close) begin
          // line end goes onto the last byte result if it is still open
          if (res_cnt != 2'd0 && res[res_cnt-2'd1].bval && !res[res_cnt-2'd1].lend) begin
            res[res_cnt-2'd1].lend = 1'b1;
          end else if (res_cnt != 2'd3) begin
            res[res_cnt] = '{data: 8'h00, bval: 1'b0, lend: 1'b1, lerr: 1'b0, last: 1'b0};
            res_cnt = res_cnt + 2'd1;
          end
          len_nxt  = '0;
          open_nxt = 1'b0;
          cr_nxt   = 1'b0;
        end
      end
    end

    if (res_cnt != 2'd0) begin
      res[res_cnt-2'd1].last = 1'b1;
    end
  end

  always_comb begin
    occ_nxt  = occ_r;
    head_nxt = head_r;
    if (in_acc) begin
      occ_nxt  = res_cnt;
      head_nxt = 2'd0;
    end else if (out_acc) begin
      occ_nxt  = occ_r - 2'd1;
      head_nxt = head_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lts_pkg::MODE_LF_ONLY;
      keep_r    <= 1'b0;
      max_len_r <= lts_pkg::MAX_LINE_LEN_RST;
      len_r     <= '0;
      cr_r      <= 1'b0;
      open_r    <= 1'b0;
      fail_r    <= 1'b0;
      occ_r     <= 2'd0;
      head_r    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lts_pkg::CFG_NEWLINE_MODE: mode_r    <= cfg_data[1:0];
          lts_pkg::CFG_KEEP_NEWLINE: keep_r    <= cfg_data[0];
          lts_pkg::CFG_MAX_LINE_LEN: max_len_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        len_r  <= len_nxt;
        cr_r   <= cr_nxt;
        open_r <= open_nxt;
        fail_r <= fail_nxt;
      end
      occ_r  <= occ_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int j = 0; j < lts_pkg::MAX_RESULTS; j++) begin
        buf_r[j] <= res[j];
      end
    end
  end

`ifndef ASSERT_OFF
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r != 2'd0 || !in_stall)
    else $error("stall raised with an empty result buffer");

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(head_r) + 32'(occ_r) <= 32'(lts_pkg::MAX_RESULTS)))
    else $error("result buffer read past its last entry");

  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fail_r && in_acc) |=> !out_valid)
    else $error("failed block produced a result");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_length_error) |-> (out_line_end && out_last_result && !out_out_valid))
    else $error("length error result malformed");
`endif

endmodule
